/* design/ss_pkg.sv */
// ----------------------------------------------------------------------------
// ss_pkg: shared types for the selection sorter
// Holds the sequencer states and the control group that drives the compare unit.
// ----------------------------------------------------------------------------
package ss_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SCAN,
    ST_DRAIN,
    ST_SWAP,
    ST_OUT
  } state_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic vld;    // read data is a live entry
    logic first;  // entry is the head of the unsorted rest
  } scan_ctl_t;

endpackage

/* design/ss_ram.sv */
// ----------------------------------------------------------------------------
// ss_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ss_scan.sv */
// ----------------------------------------------------------------------------
// ss_scan: running-minimum compare unit
// One signed comparator; tracks the minimum, its index, and the head entry.
// ----------------------------------------------------------------------------
module ss_scan #(
  parameter int IW = 6
) (
  input  logic                     clk,
  input  ss_pkg::scan_ctl_t        ctl,
  input  logic [ss_pkg::DATA_W-1:0] rd_data,
  input  logic [IW-1:0]            rd_idx,
  output logic [ss_pkg::DATA_W-1:0] min_val,
  output logic [IW-1:0]            pick_idx,
  output logic [ss_pkg::DATA_W-1:0] head_val
);
  import ss_pkg::*;

  logic [DATA_W-1:0] min_r;
  logic [IW-1:0]     pick_r;
  logic [DATA_W-1:0] head_r;
  logic              less;

  // strict less keeps the first of equal minima
  assign less = $signed(rd_data) < $signed(min_r);

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      if (ctl.first) begin
        min_r  <= rd_data;
        pick_r <= rd_idx;
        head_r <= rd_data;
      end else if (less) begin
        min_r  <= rd_data;
        pick_r <= rd_idx;
      end
    end
  end

  assign min_val  = min_r;
  assign pick_idx = pick_r;
  assign head_val = head_r;

endmodule

/* design/selection_sort_top.sv */
// ----------------------------------------------------------------------------
// selection_sort_top: streaming selection sorter
// Collects signed values until tlast, then emits them in ascending order.
// ----------------------------------------------------------------------------
// Values are accepted one per cycle into a MAX_LEN-entry RAM until a request
// with tlast arrives; requests beyond MAX_LEN are dropped and every result of
// that run carries overflow in out_tuser. The block then stops taking input and
// emits one result per pass: a pass reads the unsorted rest of the RAM through
// its single read port into one shared comparator, then moves the head value into
// the slot the minimum came from and holds the result until out_tready takes it.
// Input is taken again once the final result (out_tlast) has been delivered.
module selection_sort_top #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_res
  output logic        out_tlast,
  output logic        out_tuser   // [0] overflow
);
  import ss_pkg::*;

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [IW-1:0] last_idx_r, last_idx_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;

  scan_ctl_t     ctl_r;
  logic [IW-1:0] idx_r;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic              in_acc, out_acc, room;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] min_val, head_val;
  logic [IW-1:0]     pick_idx;

  assign in_tready = (state_r == ST_COLLECT);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid_r & out_tready;
  assign room      = count_r < CW'(MAX_LEN);

  // swap writes the head value into the slot the minimum came from
  assign we    = (state_r == ST_SWAP) | (in_acc & room);
  assign waddr = (state_r == ST_SWAP) ? pick_idx : count_r[IW-1:0];
  assign wdata = (state_r == ST_SWAP) ? head_val : in_tdata;

  ss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (j_r),
    .rdata (rdata)
  );

  ss_scan #(
    .IW (IW)
  ) u_scan (
    .clk      (clk),
    .ctl      (ctl_r),
    .rd_data  (rdata),
    .rd_idx   (idx_r),
    .min_val  (min_val),
    .pick_idx (pick_idx),
    .head_val (head_val)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dropped_nxt    = dropped_r;
    last_idx_nxt   = last_idx_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    out_tvalid_nxt = out_tvalid_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          if (room) begin
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_tlast) begin
            last_idx_nxt = room ? count_r[IW-1:0] : IW'(MAX_LEN - 1);
            i_nxt        = '0;
            j_nxt        = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (j_r == last_idx_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SWAP;
      end
      ST_SWAP: begin
        out_tvalid_nxt = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          out_tvalid_nxt = 1'b0;
          if (i_r == last_idx_r) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_COLLECT;
          end else begin
            i_nxt     = i_r + IW'(1);
            j_nxt     = i_r + IW'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_COLLECT;
      count_r      <= '0;
      dropped_r    <= 1'b0;
      last_idx_r   <= '0;
      i_r          <= '0;
      j_r          <= '0;
      ctl_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dropped_r    <= dropped_nxt;
      last_idx_r   <= last_idx_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      ctl_r.vld    <= (state_r == ST_SCAN);
      ctl_r.first  <= (j_r == i_r);
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // read index travels alongside the registered RAM read
  always_ff @(posedge clk) begin
    idx_r <= j_r;
    if (state_r == ST_SWAP) begin
      out_data_r <= min_val;
      out_last_r <= (i_r == last_idx_r);
      out_ovf_r  <= dropped_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (j_r >= i_r && i_r <= last_idx_r))
    else $error("scan index outside unsorted rest");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (count_r == '0 && !dropped_r && in_tready))
    else $error("run state not cleared after final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("element count beyond store depth");
`endif

endmodule
